// ===== rtl/scdc_pkg.sv =====
// ----------------------------------------------------------------------------
// scdc_pkg - solar charge duty controller shared definitions
// Widths, register indexes, mode codes and the stage payload type.
// ----------------------------------------------------------------------------
package scdc_pkg;

   // defaults for the top level parameters
   localparam int AdcBitsDef    = 10;
   localparam int DutyMarginDef = 10;
   localparam int MaxStepDef    = 20;

   // fixed field widths
   localparam int DutyW    = 8;
   localparam int RspStepW = 6;
   localparam int StepW    = 8;   // signed internal step, holds +-127
   localparam int StepMagW = 7;
   localparam int GainW    = 16;
   localparam int CsrDataW = 16;
   localparam int CsrIdxW  = 3;

   localparam logic [DutyW-1:0] DutyResetVal = 8'd100;
   localparam logic [GainW-1:0] GainResetVal = 16'd256;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CsrMode          = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrGain          = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrVoltTarget    = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrCurrTarget    = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrSoftCurrLimit = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrInvertStep    = 3'd5;

   // step rule codes
   localparam logic [1:0] ModeCv    = 2'd0;
   localparam logic [1:0] ModeCc    = 2'd1;
   localparam logic [1:0] ModeMppt  = 2'd2;
   localparam logic [1:0] ModeReset = ModeMppt;

   // item actions
   localparam logic ActSample = 1'b0;
   localparam logic ActClear  = 1'b1;

   // what the front stage hands to the update stage
   typedef struct packed {
      logic                     action;
      logic                     track;       // tracking mode step
      logic                     invert;
      logic                     over_limit;  // panel current above soft limit
      logic signed [StepW-1:0]  fixed_step;  // proportional step, zero otherwise
   } stage_type;

endpackage

// ===== rtl/scdc_prep.sv =====
// ----------------------------------------------------------------------------
// scdc_prep - front stage
// Registers the item together with its proportional step, panel power and
// current-limit flag.
// ----------------------------------------------------------------------------
module scdc_prep #(
   parameter int ADC_BITS = scdc_pkg::AdcBitsDef,
   parameter int MAX_STEP = scdc_pkg::MaxStepDef
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_action,
   input  logic [ADC_BITS-1:0]         req_panel_v,
   input  logic [ADC_BITS-1:0]         req_panel_i,
   input  logic [ADC_BITS-1:0]         req_batt_v,
   input  logic [1:0]                  cfg_mode,
   input  logic [scdc_pkg::GainW-1:0]  cfg_gain,
   input  logic [ADC_BITS-1:0]         cfg_volt_target,
   input  logic [ADC_BITS-1:0]         cfg_curr_target,
   input  logic [ADC_BITS-1:0]         cfg_soft_curr_limit,
   input  logic                        cfg_invert_step,
   output logic                        stage_valid,
   input  logic                        stage_ready,
   output scdc_pkg::stage_type         stage_data,
   output logic [2*ADC_BITS-1:0]       stage_power
);

   localparam int PowerW = 2 * ADC_BITS;

   logic                              valid_ff, valid_in;
   scdc_pkg::stage_type               data_ff, data_in;
   logic [PowerW-1:0]                 power_ff, power_in;
   logic                              take;

   logic [ADC_BITS-1:0]               target, sample, err;
   logic                              err_pos;
   logic [31:0]                       prod;
   logic [23:0]                       mag_full;
   logic [scdc_pkg::StepMagW-1:0]     mag;
   logic signed [scdc_pkg::StepW-1:0] prop;

   assign req_ready = !valid_ff || stage_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      target  = (cfg_mode == scdc_pkg::ModeCc) ? cfg_curr_target : cfg_volt_target;
      sample  = (cfg_mode == scdc_pkg::ModeCc) ? req_panel_i : req_batt_v;
      err_pos = target >= sample;
      err     = err_pos ? target - sample : sample - target;
      // 32-bit product wraps as the unsigned arithmetic does
      prod     = 32'(cfg_gain) * 32'(err);
      mag_full = prod[31:8];
      mag      = (mag_full > 24'(MAX_STEP)) ? scdc_pkg::StepMagW'(MAX_STEP)
                                            : mag_full[scdc_pkg::StepMagW-1:0];
      prop     = err_pos ? signed'({1'b0, mag}) : -signed'({1'b0, mag});
   end

   always_comb begin
      data_in.action     = req_action;
      data_in.track      = (cfg_mode == scdc_pkg::ModeMppt);
      data_in.invert     = cfg_invert_step;
      data_in.over_limit = req_panel_i > cfg_soft_curr_limit;
      if (req_action == scdc_pkg::ActSample &&
          (cfg_mode == scdc_pkg::ModeCv || cfg_mode == scdc_pkg::ModeCc)) begin
         data_in.fixed_step = prop;
      end else begin
         data_in.fixed_step = '0;
      end
      power_in = PowerW'(req_panel_v) * PowerW'(req_panel_i);
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (stage_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff  <= data_in;
         power_ff <= power_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;
   assign stage_power = power_ff;

endmodule

// ===== rtl/scdc_update.sv =====
// ----------------------------------------------------------------------------
// scdc_update - update stage
// Runs perturb-and-observe, applies the step to the duty register inside the
// margin bounds and holds the result item.
// ----------------------------------------------------------------------------
module scdc_update #(
   parameter int ADC_BITS    = scdc_pkg::AdcBitsDef,
   parameter int DUTY_MARGIN = scdc_pkg::DutyMarginDef
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 stage_valid,
   output logic                                 stage_ready,
   input  scdc_pkg::stage_type                  stage_data,
   input  logic [2*ADC_BITS-1:0]                stage_power,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [scdc_pkg::DutyW-1:0]           rsp_duty,
   output logic signed [scdc_pkg::RspStepW-1:0] rsp_step,
   output logic                                 rsp_applied
);

   localparam int PowerW = 2 * ADC_BITS;
   localparam logic signed [10:0] MarginS = 11'(DUTY_MARGIN);
   localparam logic [scdc_pkg::DutyW-1:0] DutyLow  = scdc_pkg::DutyW'(DUTY_MARGIN + 1);
   localparam logic [scdc_pkg::DutyW-1:0] DutyHigh = scdc_pkg::DutyW'(254 - DUTY_MARGIN);

   logic [scdc_pkg::DutyW-1:0]          duty_ff, duty_in;
   logic [PowerW-1:0]                   last_power_ff, last_power_in;
   logic                                dir_up_ff, dir_up_in;
   logic                                out_valid_ff, out_valid_in;
   logic signed [scdc_pkg::RspStepW-1:0] out_step_ff;
   logic                                applied_ff, applied_in;
   logic                                fire;

   logic signed [scdc_pkg::StepW-1:0]   step_s, step_a;
   logic signed [10:0]                  a_w, d_w;

   assign stage_ready = !out_valid_ff || rsp_ready;
   assign fire        = stage_valid && stage_ready;

   // tracking step and history
   always_comb begin
      step_s        = stage_data.fixed_step;
      dir_up_in     = dir_up_ff;
      last_power_in = last_power_ff;
      if (stage_data.action == scdc_pkg::ActClear) begin
         step_s        = '0;
         dir_up_in     = 1'b0;
         last_power_in = '0;
      end else if (stage_data.track) begin
         if (stage_power > last_power_ff) begin
            step_s = dir_up_ff ? 8'sd1 : -8'sd1;
         end else begin
            step_s    = dir_up_ff ? -8'sd1 : 8'sd1;
            dir_up_in = !dir_up_ff;
         end
         if (stage_data.over_limit) begin
            step_s    = -8'sd1;
            dir_up_in = 1'b0;
         end
         last_power_in = stage_power;
      end
   end

   // duty update with margin clamp
   always_comb begin
      step_a     = stage_data.invert ? -step_s : step_s;
      a_w        = 11'(step_a);
      d_w        = signed'({3'b000, duty_ff});
      duty_in    = duty_ff;
      applied_in = 1'b0;
      if (stage_data.action == scdc_pkg::ActSample) begin
         if (a_w < 11'sd0) begin
            if (-a_w >= d_w - MarginS) begin
               duty_in = DutyLow;
            end else begin
               duty_in    = 8'(d_w + a_w);
               applied_in = 1'b1;
            end
         end else begin
            if (a_w >= 11'sd255 - d_w - MarginS) begin
               duty_in = DutyHigh;
            end else begin
               duty_in    = 8'(d_w + a_w);
               applied_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         duty_ff       <= scdc_pkg::DutyResetVal;
         last_power_ff <= '0;
         dir_up_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            duty_ff       <= duty_in;
            last_power_ff <= last_power_in;
            dir_up_ff     <= dir_up_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_step_ff <= step_s[scdc_pkg::RspStepW-1:0];
         applied_ff  <= applied_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_duty    = duty_ff;
   assign rsp_step    = out_step_ff;
   assign rsp_applied = applied_ff;

endmodule

// ===== rtl/solar_charge_duty_controller_top.sv =====
// ----------------------------------------------------------------------------
// solar_charge_duty_controller_top - charge controller duty update
// CV / CC proportional stepping and perturb-and-observe tracking on panel
// power, applied to a margin-bounded duty register, one result per item.
//
//   channel  ports           direction  content
//   request  req_*           in         action, panel_v, panel_i, batt_v
//   result   rsp_*           out        duty, step, applied
//   config   csr_*           in         write enable, index, 16-bit data
//
// Two register stages: the front stage registers the proportional step and
// panel power, the update stage applies the step and holds the result.
// One item per cycle sustained while results are taken; a result passes
// through the front and update stage registers before it is offered.
// Reset restores the registers to their defaults, duty to 100 and clears the
// tracking history. A stalled result holds both stages once they fill.
// ----------------------------------------------------------------------------
module solar_charge_duty_controller_top #(
   parameter int ADC_BITS    = scdc_pkg::AdcBitsDef,
   parameter int DUTY_MARGIN = scdc_pkg::DutyMarginDef,
   parameter int MAX_STEP    = scdc_pkg::MaxStepDef
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic [ADC_BITS-1:0]                  req_panel_v,
   input  logic [ADC_BITS-1:0]                  req_panel_i,
   input  logic [ADC_BITS-1:0]                  req_batt_v,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [scdc_pkg::DutyW-1:0]           rsp_duty,
   output logic signed [scdc_pkg::RspStepW-1:0] rsp_step,
   output logic                                 rsp_applied,
   input  logic                                 csr_wen,
   input  logic [scdc_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [scdc_pkg::CsrDataW-1:0]        csr_wdata
);

   logic [1:0]                 mode_ff;
   logic [scdc_pkg::GainW-1:0] gain_ff;
   logic [ADC_BITS-1:0]        volt_target_ff;
   logic [ADC_BITS-1:0]        curr_target_ff;
   logic [ADC_BITS-1:0]        soft_curr_limit_ff;
   logic                       invert_step_ff;

   logic                       stage_valid, stage_ready;
   scdc_pkg::stage_type        stage_data;
   logic [2*ADC_BITS-1:0]      stage_power;

   // configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= scdc_pkg::ModeReset;
         gain_ff            <= scdc_pkg::GainResetVal;
         volt_target_ff     <= '0;
         curr_target_ff     <= '0;
         soft_curr_limit_ff <= ADC_BITS'(10'd1023);
         invert_step_ff     <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index)
            scdc_pkg::CsrMode:          mode_ff            <= csr_wdata[1:0];
            scdc_pkg::CsrGain:          gain_ff            <= csr_wdata[scdc_pkg::GainW-1:0];
            scdc_pkg::CsrVoltTarget:    volt_target_ff     <= csr_wdata[ADC_BITS-1:0];
            scdc_pkg::CsrCurrTarget:    curr_target_ff     <= csr_wdata[ADC_BITS-1:0];
            scdc_pkg::CsrSoftCurrLimit: soft_curr_limit_ff <= csr_wdata[ADC_BITS-1:0];
            scdc_pkg::CsrInvertStep:    invert_step_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   scdc_prep #(
      .ADC_BITS (ADC_BITS),
      .MAX_STEP (MAX_STEP)
   ) u_prep (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_panel_v         (req_panel_v),
      .req_panel_i         (req_panel_i),
      .req_batt_v          (req_batt_v),
      .cfg_mode            (mode_ff),
      .cfg_gain            (gain_ff),
      .cfg_volt_target     (volt_target_ff),
      .cfg_curr_target     (curr_target_ff),
      .cfg_soft_curr_limit (soft_curr_limit_ff),
      .cfg_invert_step     (invert_step_ff),
      .stage_valid         (stage_valid),
      .stage_ready         (stage_ready),
      .stage_data          (stage_data),
      .stage_power         (stage_power)
   );

   scdc_update #(
      .ADC_BITS    (ADC_BITS),
      .DUTY_MARGIN (DUTY_MARGIN)
   ) u_update (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_ready (stage_ready),
      .stage_data  (stage_data),
      .stage_power (stage_power),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_duty    (rsp_duty),
      .rsp_step    (rsp_step),
      .rsp_applied (rsp_applied)
   );

endmodule
